### sv/qts_pkg.sv
// Shared types and constants for the quadrilateral-to-triangle splitter.
// No dependencies; every other file of the block imports this package.
package qts_pkg;

    localparam int TOL_W       = 16;
    localparam int NVTX        = 4;
    localparam int NPAIR       = 6;
    localparam int SORT_STAGES = 12;
    localparam int SQRT_BITS   = 34;
    localparam int DIST_W      = SQRT_BITS;
    localparam int SUM_W       = 66;
    localparam int RAD_W       = 2 * SQRT_BITS;
    localparam int REM_W       = SQRT_BITS + 2;
    localparam int LANE_LAT    = 3 + SQRT_BITS;

    typedef logic [TOL_W-1:0]  tol_t;
    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vtx_t;

    typedef vtx_t [NVTX-1:0]    quad_t;
    typedef vtx_t [2:0]         tri_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef dist_t [NPAIR-1:0]  dist_set_t;
    typedef logic [1:0]         vidx_t;
    typedef logic [2:0]         pidx_t;

    typedef struct packed {
        logic [RAD_W-1:0]     rad;
        logic [REM_W-1:0]     rem;
        logic [SQRT_BITS-1:0] root;
    } sq_t;

    localparam tol_t TOL_RESET = 16'd7;

    localparam vidx_t PAIR_A [NPAIR] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam vidx_t PAIR_B [NPAIR] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

### sv/qts_if.sv
// Handshake channels of the splitter: quad input, triangle output, tolerance write.
// Depends on qts_pkg for the coordinate and tolerance types.
interface qts_quad_if;
    import qts_pkg::*;
    logic   valid;
    logic   ready;
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t p3_x;
    coord_t p3_y;
    coord_t p3_z;
    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
    modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                    p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface qts_tri_if;
    import qts_pkg::*;
    logic   valid;
    logic   ready;
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    logic   last;
    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, last, input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, last, output ready);
endinterface

interface qts_cfg_if;
    import qts_pkg::*;
    logic valid;
    logic ready;
    tol_t tolerance;
    modport source (output valid, tolerance, input ready);
    modport sink   (input valid, tolerance, output ready);
endinterface

### sv/qts_sort.sv
// Twelve-stage compare-and-swap network ordering the four vertices by x, y, z.
// Depends on qts_pkg.
module qts_sort (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  qts_pkg::quad_t in_quad,
    input  qts_pkg::tol_t  tolerance,
    output logic          out_valid,
    output qts_pkg::quad_t out_quad
);
    import qts_pkg::*;

    quad_t q_reg [SORT_STAGES];
    logic  v_reg [SORT_STAGES];
    quad_t stage_in [SORT_STAGES];
    logic  stage_v [SORT_STAGES];

    function automatic logic ge_tol(coord_t a, coord_t b, tol_t t);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d >= $signed({17'b0, t});
    endfunction

    function automatic logic must_swap(vtx_t a, vtx_t b, tol_t t);
        logic r;
        if (ge_tol(a.x, b.x, t))
            r = 1'b1;
        else if (ge_tol(b.x, a.x, t))
            r = 1'b0;
        else if (ge_tol(a.y, b.y, t))
            r = 1'b1;
        else if (ge_tol(b.y, a.y, t))
            r = 1'b0;
        else
            r = ge_tol(a.z, b.z, t);
        return r;
    endfunction

    for (genvar s = 0; s < SORT_STAGES; s++)
    begin : g_stage
        localparam int J = s % 3;
        quad_t cur;

        if (s == 0)
        begin : g_first
            assign stage_in[s] = in_quad;
            assign stage_v[s]  = in_valid;
        end
        else
        begin : g_rest
            assign stage_in[s] = q_reg[s-1];
            assign stage_v[s]  = v_reg[s-1];
        end

        always_comb
        begin
            cur = stage_in[s];
            if (must_swap(stage_in[s][J], stage_in[s][J+1], tolerance))
            begin
                cur[J]   = stage_in[s][J+1];
                cur[J+1] = stage_in[s][J];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= stage_v[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                q_reg[s] <= cur;
        end
    end

    assign out_valid = v_reg[SORT_STAGES-1];
    assign out_quad  = q_reg[SORT_STAGES-1];

endmodule

### sv/qts_dist_lane.sv
// One distance lane: absolute differences, squares, sum, then a one-bit-per-stage root.
// Depends on qts_pkg.
module qts_dist_lane (
    input  logic          clk,
    input  logic          en,
    input  qts_pkg::vtx_t a,
    input  qts_pkg::vtx_t b,
    output qts_pkg::dist_t dist_out
);
    import qts_pkg::*;

    logic [31:0]      dx_reg, dy_reg, dz_reg;
    logic [63:0]      sx_reg, sy_reg, sz_reg;
    logic [SUM_W-1:0] sum_reg;
    sq_t              sq_reg [SQRT_BITS];
    sq_t              sq_init;

    function automatic logic [31:0] absdiff(coord_t p, coord_t q);
        logic signed [32:0] d;
        logic signed [32:0] m;
        d = {p[31], p} - {q[31], q};
        m = d[32] ? -d : d;
        return m[31:0];
    endfunction

    function automatic sq_t sqrt_step(sq_t s);
        sq_t              r;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
        trial  = {s.root, 2'b01};
        r.rad  = {s.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = rem_sh - trial;
            r.root = {s.root[SQRT_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh;
            r.root = {s.root[SQRT_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        sq_init.rad  = {{(RAD_W-SUM_W){1'b0}}, sum_reg};
        sq_init.rem  = '0;
        sq_init.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg    <= absdiff(a.x, b.x);
            dy_reg    <= absdiff(a.y, b.y);
            dz_reg    <= absdiff(a.z, b.z);
            sx_reg    <= dx_reg * dx_reg;
            sy_reg    <= dy_reg * dy_reg;
            sz_reg    <= dz_reg * dz_reg;
            sum_reg   <= {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};
            sq_reg[0] <= sqrt_step(sq_init);
            for (int k = 1; k < SQRT_BITS; k++)
                sq_reg[k] <= sqrt_step(sq_reg[k-1]);
        end
    end

    assign dist_out = sq_reg[SQRT_BITS-1].root;

endmodule

### sv/qts_merge.sv
// Merge stage: near-pair and farthest-pair scan over the six lane results,
// nearest-neighbour choice, and the output register that plays out one or two triangles.
// Depends on qts_pkg and qts_if.
module qts_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qts_pkg::quad_t    in_quad,
    input  qts_pkg::dist_set_t in_dist,
    input  qts_pkg::tol_t     tolerance,
    output logic              en,
    qts_tri_if.source         triangle
);
    import qts_pkg::*;

    logic      va_reg, vb_reg, vc_reg;
    quad_t     qa_reg, qb_reg, qc_reg;
    dist_set_t da_reg, db_reg;
    logic [NPAIR-1:0] near_a_reg;
    dist_t     maxa_reg;
    pidx_t     mia_reg;
    logic      oneb_reg, onec_reg;
    vidx_t     dropb_reg, dropc_reg;
    vidx_t     sib_reg, sic_reg;
    vidx_t     n1c_reg, n2c_reg, farc_reg;
    dist_t     farm_reg [3];

    logic      ov_reg, sel_reg, two_reg;
    tri_t      tri0_reg, tri1_reg;
    tri_t      shown;

    logic [NPAIR-1:0] near_w;
    dist_t     maxa_w, maxb_w;
    pidx_t     mia_w, mib_w;
    vidx_t     drop_w;
    logic [5:0] others_w, nn_w, nn2_w, drop_oth;
    dist_t     dsel [3];
    tri_t      tri0_w, tri1_w;

    function automatic pidx_t pair_of(vidx_t p, vidx_t q);
        vidx_t lo, hi;
        pidx_t r;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        case ({lo, hi})
            4'b0001: r = 3'd0;
            4'b0010: r = 3'd1;
            4'b0011: r = 3'd2;
            4'b0110: r = 3'd3;
            4'b0111: r = 3'd4;
            4'b1011: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // the three vertex indices other than x, ascending
    function automatic logic [5:0] others(vidx_t x);
        logic [5:0] r;
        case (x)
            2'd0:    r = {2'd1, 2'd2, 2'd3};
            2'd1:    r = {2'd0, 2'd2, 2'd3};
            2'd2:    r = {2'd0, 2'd1, 2'd3};
            default: r = {2'd0, 2'd1, 2'd2};
        endcase
        return r;
    endfunction

    // returns {n1, n2, far}
    function automatic logic [5:0] nearest_two(dist_t d0, dist_t d1, dist_t d2,
                                               vidx_t t0, vidx_t t1, vidx_t t2);
        logic [5:0] r;
        if (d0 <= d2 && d1 <= d2)
            r = {t0, t1, t2};
        else if (d1 <= d0 && d2 <= d0)
            r = {t1, t2, t0};
        else
            r = {t0, t2, t1};
        return r;
    endfunction

    function automatic logic beats(dist_t d, dist_t m, tol_t t);
        logic [DIST_W:0] lim;
        lim = {1'b0, m} + {{(DIST_W+1-TOL_W){1'b0}}, t};
        return {1'b0, d} > lim;
    endfunction

    assign en = !ov_reg || (triangle.ready && (sel_reg || !two_reg));

    always_comb
    begin
        maxa_w = '0;
        mia_w  = '0;
        for (int k = 0; k < 3; k++)
        begin
            near_w[k] = in_dist[k] < {{(DIST_W-TOL_W){1'b0}}, tolerance};
            if (beats(in_dist[k], maxa_w, tolerance))
            begin
                maxa_w = in_dist[k];
                mia_w  = pidx_t'(k);
            end
        end
        for (int k = 3; k < NPAIR; k++)
            near_w[k] = in_dist[k] < {{(DIST_W-TOL_W){1'b0}}, tolerance};
    end

    always_comb
    begin
        maxb_w = maxa_reg;
        mib_w  = mia_reg;
        for (int k = 3; k < NPAIR; k++)
        begin
            if (beats(da_reg[k], maxb_w, tolerance))
            begin
                maxb_w = da_reg[k];
                mib_w  = pidx_t'(k);
            end
        end
        if (|near_a_reg[2:0])
            drop_w = 2'd0;
        else if (|near_a_reg[4:3])
            drop_w = 2'd1;
        else
            drop_w = 2'd2;
    end

    always_comb
    begin
        others_w = others(sib_reg);
        dsel[0]  = db_reg[pair_of(sib_reg, others_w[5:4])];
        dsel[1]  = db_reg[pair_of(sib_reg, others_w[3:2])];
        dsel[2]  = db_reg[pair_of(sib_reg, others_w[1:0])];
        nn_w     = nearest_two(dsel[0], dsel[1], dsel[2],
                               others_w[5:4], others_w[3:2], others_w[1:0]);
    end

    always_comb
    begin
        nn2_w    = nearest_two(farm_reg[0], farm_reg[1], farm_reg[2],
                               n1c_reg, n2c_reg, sic_reg);
        drop_oth = others(dropc_reg);
        if (onec_reg)
        begin
            tri0_w[0] = qc_reg[drop_oth[5:4]];
            tri0_w[1] = qc_reg[drop_oth[3:2]];
            tri0_w[2] = qc_reg[drop_oth[1:0]];
        end
        else
        begin
            tri0_w[0] = qc_reg[sic_reg];
            tri0_w[1] = qc_reg[n1c_reg];
            tri0_w[2] = qc_reg[n2c_reg];
        end
        tri1_w[0] = qc_reg[farc_reg];
        tri1_w[1] = qc_reg[nn2_w[5:4]];
        tri1_w[2] = qc_reg[nn2_w[3:2]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            sel_reg <= 1'b0;
            two_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg  <= in_valid;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
            ov_reg  <= vc_reg;
            sel_reg <= 1'b0;
            two_reg <= !onec_reg;
        end
        else if (triangle.ready)
        begin
            sel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qa_reg     <= in_quad;
            da_reg     <= in_dist;
            near_a_reg <= near_w;
            maxa_reg   <= maxa_w;
            mia_reg    <= mia_w;
            qb_reg     <= qa_reg;
            db_reg     <= da_reg;
            oneb_reg   <= |near_a_reg;
            dropb_reg  <= drop_w;
            sib_reg    <= PAIR_A[mib_w];
            qc_reg     <= qb_reg;
            onec_reg   <= oneb_reg;
            dropc_reg  <= dropb_reg;
            sic_reg    <= sib_reg;
            n1c_reg    <= nn_w[5:4];
            n2c_reg    <= nn_w[3:2];
            farc_reg   <= nn_w[1:0];
            farm_reg[0] <= db_reg[pair_of(nn_w[1:0], nn_w[5:4])];
            farm_reg[1] <= db_reg[pair_of(nn_w[1:0], nn_w[3:2])];
            farm_reg[2] <= db_reg[pair_of(nn_w[1:0], sib_reg)];
            tri0_reg   <= tri0_w;
            tri1_reg   <= tri1_w;
        end
    end

    assign shown          = sel_reg ? tri1_reg : tri0_reg;
    assign triangle.valid = ov_reg;
    assign triangle.last  = sel_reg || !two_reg;
    assign triangle.v0_x  = shown[0].x;
    assign triangle.v0_y  = shown[0].y;
    assign triangle.v0_z  = shown[0].z;
    assign triangle.v1_x  = shown[1].x;
    assign triangle.v1_y  = shown[1].y;
    assign triangle.v1_z  = shown[1].z;
    assign triangle.v2_x  = shown[2].x;
    assign triangle.v2_y  = shown[2].y;
    assign triangle.v2_z  = shown[2].z;

endmodule

### sv/quad_to_triangle_split.sv
// An accepted quad passes the sort network, the distance lanes and the merge registers
// before its first triangle appears. One quad a cycle when it yields one triangle and the sink
// is ready; one yielding two holds the pipeline, as the single output register plays out both.
// The whole pipeline holds while the output register waits on its sink.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the tolerance to 7.
module quad_to_triangle_split (
    input  logic      clk,
    input  logic      rst_n,
    qts_cfg_if.sink   cfg,
    qts_quad_if.sink  quad,
    qts_tri_if.source triangle
);
    import qts_pkg::*;

    tol_t      tol_reg;
    logic      en;
    quad_t     in_q;
    logic      sv;
    quad_t     sq;
    logic      dv_reg [LANE_LAT];
    quad_t     dq_reg [LANE_LAT];
    dist_set_t pair_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg.valid)
            tol_reg <= cfg.tolerance;
    end

    assign cfg.ready  = 1'b1;
    assign quad.ready = en;

    always_comb
    begin
        in_q[0] = '{x: quad.p0_x, y: quad.p0_y, z: quad.p0_z};
        in_q[1] = '{x: quad.p1_x, y: quad.p1_y, z: quad.p1_z};
        in_q[2] = '{x: quad.p2_x, y: quad.p2_y, z: quad.p2_z};
        in_q[3] = '{x: quad.p3_x, y: quad.p3_y, z: quad.p3_z};
    end

    qts_sort u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quad.valid),
        .in_quad   (in_q),
        .tolerance (tol_reg),
        .out_valid (sv),
        .out_quad  (sq)
    );

    for (genvar k = 0; k < NPAIR; k++)
    begin : g_lane
        qts_dist_lane u_lane (
            .clk      (clk),
            .en       (en),
            .a        (sq[PAIR_A[k]]),
            .b        (sq[PAIR_B[k]]),
            .dist_out (pair_dist[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= sv;
            for (int i = 1; i < LANE_LAT; i++)
                dv_reg[i] <= dv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dq_reg[0] <= sq;
            for (int i = 1; i < LANE_LAT; i++)
                dq_reg[i] <= dq_reg[i-1];
        end
    end

    qts_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_reg[LANE_LAT-1]),
        .in_quad   (dq_reg[LANE_LAT-1]),
        .in_dist   (pair_dist),
        .tolerance (tol_reg),
        .en        (en),
        .triangle  (triangle)
    );

endmodule

### sv/qts_checker.sv
// Port-level checks on the splitter's output sequencing and input acceptance.
// Depends on qts_pkg; bound to quad_to_triangle_split below.
module qts_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            quad_ready,
    input logic            cfg_ready,
    input logic            tri_valid,
    input logic            tri_ready,
    input logic            tri_last,
    input qts_pkg::coord_t tri_v0_x,
    input qts_pkg::coord_t tri_v2_z
);
    import qts_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && !tri_ready |=> tri_valid && $stable(tri_v0_x) && $stable(tri_v2_z)
            && $stable(tri_last))
        else $error("stalled triangle changed");

    assert property (@(posedge clk) !rst_n |-> !tri_valid)
        else $error("triangle valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && tri_ready && !tri_last |=> tri_valid && tri_last)
        else $error("second triangle of a pair missing");

    assert property (@(posedge clk) disable iff (!rst_n)
        !tri_valid |-> quad_ready && cfg_ready)
        else $error("input held with output empty");

endmodule

bind quad_to_triangle_split qts_checker u_qts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .quad_ready (quad.ready),
    .cfg_ready  (cfg.ready),
    .tri_valid  (triangle.valid),
    .tri_ready  (triangle.ready),
    .tri_last   (triangle.last),
    .tri_v0_x   (triangle.v0_x),
    .tri_v2_z   (triangle.v2_z)
);
